[hdl/assert_macros.svh]
// Assertion macros for the timer RTL.
// Standalone header; the timer core includes it to check its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a condition in the same cycle as its trigger.
`define KCT_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kct assertion failed (same cycle)");

// Check a condition in the cycle after its trigger.
`define KCT_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kct assertion failed (next cycle)");

`else

`define KCT_ASSERT_IMPL(name, clk, rst, ante, cons)
`define KCT_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

[hdl/kct_pkg.sv]
// Types, codes and display helpers for the keypad countdown timer.
// No dependencies; imported by the timer core.
package kct_pkg;

  localparam int TIME_W     = 32;
  localparam int SECS_W     = 13;
  localparam int KEY_W      = 4;
  localparam int SEG_W      = 8;
  localparam int MODE_W     = 3;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;

  // Run modes
  localparam logic [MODE_W-1:0] MODE_STANDBY = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PRE     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DOWN    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_UP      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FLASH   = 3'd4;

  // Key codes
  localparam logic [KEY_W-1:0] KEY_MAX_DIGIT = 4'd9;
  localparam logic [KEY_W-1:0] KEY_A         = 4'd10;
  localparam logic [KEY_W-1:0] KEY_B         = 4'd11;
  localparam logic [KEY_W-1:0] KEY_STAR      = 4'd14;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF_PERIOD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WARNING_SECONDS   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FLASH_SECONDS     = 2'd3;

  // Configuration reset values
  localparam logic [15:0] TICKS_PER_SECOND_RST  = 16'd1000;
  localparam logic [15:0] FLASH_HALF_PERIOD_RST = 16'd250;
  localparam logic [5:0]  WARNING_SECONDS_RST   = 6'd10;
  localparam logic [5:0]  FLASH_SECONDS_RST     = 6'd10;

  localparam logic [SECS_W-1:0] MAX_SECS = 13'd5999;
  localparam logic [SEG_W-1:0]  SEG_DP   = 8'h80;

  typedef logic [SEG_W-1:0] seg_t;
  typedef seg_t [3:0] display_t;

  // MM:SS kept as decimal digits next to the binary seconds count
  typedef struct packed {
    logic [3:0] min_tens;
    logic [3:0] min_ones;
    logic [3:0] sec_tens;
    logic [3:0] sec_ones;
  } clock_digits_t;

  // Seven-segment pattern of one decimal digit, a = bit 0
  function automatic seg_t seg_digit(input logic [3:0] d);
    seg_t s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // MM:SS with a blank leading zero and the colon on the middle digits
  function automatic display_t show_time(input clock_digits_t t, input logic colon);
    display_t d;
    d[0] = (t.min_tens == 4'd0) ? 8'h00 : seg_digit(t.min_tens);
    d[1] = seg_digit(t.min_ones) | (colon ? SEG_DP : 8'h00);
    d[2] = seg_digit(t.sec_tens) | (colon ? SEG_DP : 8'h00);
    d[3] = seg_digit(t.sec_ones);
    return d;
  endfunction

  // Advance MM:SS by one second; caller guards saturation
  function automatic clock_digits_t digits_inc(input clock_digits_t t);
    clock_digits_t r;
    r = t;
    if (t.sec_ones != 4'd9) begin
      r.sec_ones = t.sec_ones + 4'd1;
    end else begin
      r.sec_ones = 4'd0;
      if (t.sec_tens != 4'd5) begin
        r.sec_tens = t.sec_tens + 4'd1;
      end else begin
        r.sec_tens = 4'd0;
        if (t.min_ones != 4'd9) begin
          r.min_ones = t.min_ones + 4'd1;
        end else begin
          r.min_ones = 4'd0;
          r.min_tens = t.min_tens + 4'd1;
        end
      end
    end
    return r;
  endfunction

  // Step MM:SS back by one second; caller guards zero
  function automatic clock_digits_t digits_dec(input clock_digits_t t);
    clock_digits_t r;
    r = t;
    if (t.sec_ones != 4'd0) begin
      r.sec_ones = t.sec_ones - 4'd1;
    end else begin
      r.sec_ones = 4'd9;
      if (t.sec_tens != 4'd0) begin
        r.sec_tens = t.sec_tens - 4'd1;
      end else begin
        r.sec_tens = 4'd5;
        if (t.min_ones != 4'd0) begin
          r.min_ones = t.min_ones - 4'd1;
        end else begin
          r.min_ones = 4'd9;
          r.min_tens = t.min_tens - 4'd1;
        end
      end
    end
    return r;
  endfunction

endpackage

[hdl/keypad_countdown_timer_display_core.sv]
// Keypad minute timer with a four-digit seven-segment display.
// Uses kct_pkg and the assertion macros in assert_macros.svh.
//
// Input stream: s_tuser marks the item kind (0 = millisecond tick,
// 1 = key press), s_tdata[3:0] holds the key code. Every accepted item
// produces exactly one result transfer on the output stream, carrying the
// four digit patterns, run mode, pause flag, entered digit count and the
// current seconds count.
// The result is on m_tvalid in the cycle after the input transfer.
// Throughput: one item per cycle while m_tready is high. The whole state
// update for an item is one pass of logic into the state registers, which
// also drive m_tdata. While a result waits on m_tready low, s_tready is
// low; an input is taken in the same cycle the pending result is taken.
// Configuration: write cfg_data to register cfg_index with cfg_we, only
// while the streams are idle. Index 0 ticks per second, 1 flash half
// period, 2 warning seconds, 3 flash seconds.
// Reset (rst, synchronous): idle mode, blank display, no digits entered,
// registers at 1000, 250, 10, 10, output stream empty.
`include "assert_macros.svh"

module keypad_countdown_timer_display_core (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [kct_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [kct_pkg::CFG_DATA_W-1:0]     cfg_data,
  // input stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [kct_pkg::IN_TDATA_W-1:0]     s_tdata,  // [3:0] key_code
  input  logic                               s_tuser,  // [0] kind
  // output stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] digit0_segments, [15:8] digit1_segments, [23:16] digit2_segments,
  // [31:24] digit3_segments, [34:32] run_mode, [35] is_paused,
  // [37:36] entered_count, [50:38] seconds_value, rest zero
  output logic [kct_pkg::OUT_TDATA_W-1:0]    m_tdata
);
  import kct_pkg::*;

  // Configuration registers
  logic [15:0] ticks_per_second;
  logic [15:0] flash_half_period;
  logic [5:0]  warning_seconds;
  logic [5:0]  flash_seconds;

  // Timer state
  logic [TIME_W-1:0] time_now, time_now_next;
  logic [TIME_W-1:0] second_mark, second_mark_next;
  logic [TIME_W-1:0] phase_mark, phase_mark_next;
  logic [MODE_W-1:0] mode, mode_next;
  logic              paused, paused_next;
  logic              up_dir, up_dir_next;
  logic [SECS_W-1:0] total_secs, total_secs_next;
  clock_digits_t     clock_digits, clock_digits_next;
  logic [SECS_W-1:0] target_secs, target_secs_next;
  logic [2:0]        precount_pos, precount_pos_next;
  logic [5:0]        flash_left, flash_left_next;
  logic              colon, colon_next;
  logic              flash_on, flash_on_next;
  logic              prev_star, prev_star_next;
  logic [1:0]        digit_count, digit_count_next;
  logic [3:0]        store_first, store_first_next;
  logic [3:0]        store_second, store_second_next;
  display_t          display, display_next;

  logic              accept;
  logic              m_tvalid_next;
  logic [KEY_W-1:0]  key;
  logic [TIME_W-1:0] now_inc;
  logic [TIME_W-1:0] sec_elapsed;
  logic [TIME_W-1:0] phase_elapsed;
  logic              sec_due;
  logic              phase_due;
  logic              flash_due;
  logic              can_inc;
  logic              can_dec;
  logic [3:0]        start_tens;
  logic [3:0]        start_ones;
  logic [6:0]        start_mins;
  logic [SECS_W-1:0] start_secs;
  logic              start_up;

  // Handshake: take an item whenever the output slot is free or draining
  assign s_tready      = !m_tvalid || m_tready;
  assign accept        = s_tvalid && s_tready;
  assign m_tvalid_next = accept ? 1'b1 : (m_tready ? 1'b0 : m_tvalid);
  assign key           = s_tdata[KEY_W-1:0];

  // Elapsed-time compares against the marks, seen after this tick
  assign now_inc       = time_now + 32'd1;
  assign sec_elapsed   = now_inc - second_mark;
  assign phase_elapsed = now_inc - phase_mark;
  assign sec_due       = sec_elapsed >= {16'd0, ticks_per_second};
  assign phase_due     = phase_elapsed >= {16'd0, ticks_per_second};
  assign flash_due     = phase_elapsed >= {16'd0, flash_half_period};
  assign can_inc       = total_secs < MAX_SECS;
  assign can_dec       = total_secs != '0;

  // Minutes entered at the keypad, with a single digit read as ones
  assign start_tens = (digit_count == 2'd1) ? 4'd0 : store_first;
  assign start_ones = (digit_count == 2'd1) ? store_first : store_second;
  assign start_mins = {3'b000, start_tens} * 7'd10 + {3'b000, start_ones};
  assign start_secs = {6'b000000, start_mins} * 13'd60;
  assign start_up   = key == KEY_B;

  // Next-state logic for one item
  always_comb begin
    time_now_next     = time_now;
    second_mark_next  = second_mark;
    phase_mark_next   = phase_mark;
    mode_next         = mode;
    paused_next       = paused;
    up_dir_next       = up_dir;
    total_secs_next   = total_secs;
    clock_digits_next = clock_digits;
    target_secs_next  = target_secs;
    precount_pos_next = precount_pos;
    flash_left_next   = flash_left;
    colon_next        = colon;
    flash_on_next     = flash_on;
    prev_star_next    = prev_star;
    digit_count_next  = digit_count;
    store_first_next  = store_first;
    store_second_next = store_second;
    display_next      = display;

    if (accept && !s_tuser) begin
      // Millisecond tick: advance time, then step the running mode
      time_now_next = now_inc;
      if (!paused) begin
        unique case (mode)
          MODE_PRE: begin
            if (phase_due) begin
              if (precount_pos < 3'd4) begin
                display_next = '0;
                display_next[precount_pos[1:0]] =
                  seg_digit(4'd3 - {2'b00, precount_pos[1:0]});
                precount_pos_next = precount_pos + 3'd1;
                phase_mark_next   = now_inc;
              end else begin
                second_mark_next = now_inc;
                colon_next       = 1'b0;
                mode_next        = up_dir ? MODE_UP : MODE_DOWN;
              end
            end
          end
          MODE_DOWN: begin
            if (sec_due) begin
              second_mark_next = second_mark + {16'd0, ticks_per_second};
              colon_next       = !colon;
              if (can_dec) begin
                total_secs_next   = total_secs - 13'd1;
                clock_digits_next = digits_dec(clock_digits);
              end
              display_next = show_time(clock_digits_next, colon_next);
            end
            if (total_secs_next <= {7'd0, warning_seconds}) begin
              mode_next       = MODE_FLASH;
              flash_left_next = flash_seconds;
              flash_on_next   = 1'b1;
              phase_mark_next = now_inc;
            end
          end
          MODE_UP: begin
            if (sec_due) begin
              second_mark_next = second_mark + {16'd0, ticks_per_second};
              colon_next       = !colon;
              if (can_inc) begin
                total_secs_next   = total_secs + 13'd1;
                clock_digits_next = digits_inc(clock_digits);
              end
              display_next = show_time(clock_digits_next, colon_next);
            end
            if (target_secs != '0 && total_secs_next >= target_secs) begin
              mode_next       = MODE_FLASH;
              flash_left_next = flash_seconds;
              flash_on_next   = 1'b1;
              phase_mark_next = now_inc;
            end
          end
          MODE_FLASH: begin
            // Toggle visibility, showing the time as it stood before this tick
            if (flash_due) begin
              phase_mark_next = now_inc;
              flash_on_next   = !flash_on;
              display_next    = flash_on ? '0 : show_time(clock_digits, colon);
            end
            if (sec_due) begin
              second_mark_next = second_mark + {16'd0, ticks_per_second};
              colon_next       = !colon;
              if (!up_dir && can_dec) begin
                total_secs_next   = total_secs - 13'd1;
                clock_digits_next = digits_dec(clock_digits);
              end
              if (flash_left != '0) begin
                flash_left_next = flash_left - 6'd1;
              end
            end
            if (flash_left_next == '0) begin
              mode_next    = MODE_STANDBY;
              display_next = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end else if (accept) begin
      // Key press
      unique case (mode)
        MODE_PRE: begin
          mode_next        = MODE_STANDBY;
          digit_count_next = 2'd0;
          display_next     = '0;
          prev_star_next   = key == KEY_STAR;
        end
        MODE_DOWN, MODE_UP, MODE_FLASH: begin
          if (key == KEY_STAR && prev_star) begin
            // second star in a row aborts
            mode_next        = MODE_STANDBY;
            paused_next      = 1'b0;
            digit_count_next = 2'd0;
            display_next     = '0;
          end else begin
            paused_next = !paused;
            if (paused) begin
              second_mark_next = time_now;
              phase_mark_next  = time_now;
            end
          end
          prev_star_next = key == KEY_STAR;
        end
        default: begin
          // Idle: collect digits or start a run
          if (key <= KEY_MAX_DIGIT) begin
            if (digit_count < 2'd2) begin
              if (digit_count[0]) begin
                store_second_next = key;
              end else begin
                store_first_next = key;
              end
              digit_count_next = digit_count + 2'd1;
            end else begin
              store_first_next  = store_second;
              store_second_next = key;
            end
          end else if ((key == KEY_A || key == KEY_B) && digit_count != 2'd0) begin
            up_dir_next       = start_up;
            total_secs_next   = start_up ? '0 : start_secs;
            clock_digits_next = start_up ? '0 :
                                {start_tens, start_ones, 4'd0, 4'd0};
            target_secs_next  = start_up ? start_secs : '0;
            paused_next       = 1'b0;
            precount_pos_next = 3'd0;
            phase_mark_next   = time_now - {16'd0, ticks_per_second};
            mode_next         = MODE_PRE;
            flash_left_next   = 6'd0;
            digit_count_next  = 2'd0;
          end else begin
            digit_count_next = 2'd0;
          end
        end
      endcase
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second  <= TICKS_PER_SECOND_RST;
      flash_half_period <= FLASH_HALF_PERIOD_RST;
      warning_seconds   <= WARNING_SECONDS_RST;
      flash_seconds     <= FLASH_SECONDS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TICKS_PER_SECOND:  ticks_per_second  <= cfg_data;
        CFG_FLASH_HALF_PERIOD: flash_half_period <= cfg_data;
        CFG_WARNING_SECONDS:   warning_seconds   <= cfg_data[5:0];
        CFG_FLASH_SECONDS:     flash_seconds     <= cfg_data[5:0];
        default: begin
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      time_now     <= '0;
      second_mark  <= '0;
      phase_mark   <= '0;
      mode         <= MODE_STANDBY;
      paused       <= 1'b0;
      up_dir       <= 1'b0;
      total_secs   <= '0;
      clock_digits <= '0;
      target_secs  <= '0;
      precount_pos <= '0;
      flash_left   <= '0;
      colon        <= 1'b0;
      flash_on     <= 1'b0;
      prev_star    <= 1'b0;
      digit_count  <= '0;
      store_first  <= '0;
      store_second <= '0;
      display      <= '0;
    end else begin
      m_tvalid     <= m_tvalid_next;
      time_now     <= time_now_next;
      second_mark  <= second_mark_next;
      phase_mark   <= phase_mark_next;
      mode         <= mode_next;
      paused       <= paused_next;
      up_dir       <= up_dir_next;
      total_secs   <= total_secs_next;
      clock_digits <= clock_digits_next;
      target_secs  <= target_secs_next;
      precount_pos <= precount_pos_next;
      flash_left   <= flash_left_next;
      colon        <= colon_next;
      flash_on     <= flash_on_next;
      prev_star    <= prev_star_next;
      digit_count  <= digit_count_next;
      store_first  <= store_first_next;
      store_second <= store_second_next;
      display      <= display_next;
    end
  end

  // Result payload straight from the state registers
  assign m_tdata = {5'b00000, total_secs, digit_count, paused, mode, display};

  // Digits are only collected in idle
  `KCT_ASSERT_IMPL(a_digits_only_idle, clk, rst, mode != MODE_STANDBY, digit_count == 2'd0)
  // Pause exists only for a running or flashing timer
  `KCT_ASSERT_IMPL(a_pause_running, clk, rst, paused, mode == MODE_DOWN || mode == MODE_UP || mode == MODE_FLASH)
  // Idle always shows a blank display
  `KCT_ASSERT_IMPL(a_idle_blank, clk, rst, mode == MODE_STANDBY, display == '0)
  // Every accepted tick advances the time base by one
  `KCT_ASSERT_NEXT(a_tick_advances, clk, rst, accept && !s_tuser, time_now == $past(time_now) + 32'd1)

endmodule
